/* hw/rtl/scl_pkg.sv */
package scl_pkg;

   localparam int CMD_W = 16;
   localparam int MAG_W = 17;
   localparam int SUM_W = 18;
   localparam int BUD_W = 16;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 13;
   localparam int MAX_WHEELS = 4;

   // Budget divider: 31-bit magnitude times 2^16 over a 24-bit divisor.
   localparam int BNUM_W = 47;
   localparam int BDEN_W = 24;
   // Lane divider: 17-bit magnitude times 16-bit budget over an 18-bit sum.
   localparam int LNUM_W = 33;

   localparam int BUD_LAT = BNUM_W + 5;
   localparam int LANE_LAT = LNUM_W + 2;

   localparam logic [CSR_IDX_W-1:0] CSR_POWER_OFFSET     = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAFE_BUFFER      = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_TIME_TENTHS = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CURRENT_OFFSET   = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEAD_VOLTAGE     = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOWDOWN_VOLTAGE = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_OUTPUT_POWER = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_CURRENT_SCALE    = 4'd7;

   localparam logic [1:0] MODE_NOCAP = 2'd0;
   localparam logic [1:0] MODE_DEAD  = 2'd1;
   localparam logic [1:0] MODE_RAMP  = 2'd2;
   localparam logic [1:0] MODE_FULL  = 2'd3;

   typedef struct packed {
      logic signed [6:0]  power_offset;
      logic [7:0]         safe_buffer;
      logic [6:0]         peak_time_tenths;
      logic signed [12:0] current_offset;
      logic [11:0]        dead_voltage;
      logic [11:0]        slowdown_voltage;
      logic [8:0]         max_output_power;
      logic [11:0]        current_scale;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      power_offset:     7'sd0,
      safe_buffer:      8'd10,
      peak_time_tenths: 7'd10,
      current_offset:   13'sd0,
      dead_voltage:     12'd1200,
      slowdown_voltage: 12'd1800,
      max_output_power: 9'd300,
      current_scale:    12'd819
   };

endpackage

/* hw/rtl/scl_div.sv */
module scl_div #(
   parameter int NW = 32,
   parameter int DW = 16,
   parameter int TW = 1
) (
   input  logic          clock,
   input  logic          adv,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   input  logic [TW-1:0] tag,
   output logic [NW-1:0] quo,
   output logic [TW-1:0] tag_out
);

   // One restoring step per stage; the numerator shifts out as quotient bits shift in.
   logic [DW-1:0] rem_ff [1:NW];
   logic [NW-1:0] nq_ff  [1:NW];
   logic [DW-1:0] den_ff [1:NW];
   logic [TW-1:0] tag_ff [1:NW];

   for (genvar k = 0; k < NW; k++) begin : g_step
      logic [DW-1:0] r_cur;
      logic [DW-1:0] d_cur;
      logic [NW-1:0] nq_cur;
      logic [TW-1:0] t_cur;
      logic [DW:0]   trial;
      logic          ge;

      if (k == 0) begin : g_first
         assign r_cur  = '0;
         assign d_cur  = den;
         assign nq_cur = num;
         assign t_cur  = tag;
      end else begin : g_next
         assign r_cur  = rem_ff[k];
         assign d_cur  = den_ff[k];
         assign nq_cur = nq_ff[k];
         assign t_cur  = tag_ff[k];
      end

      assign trial = {r_cur, nq_cur[NW-1]};
      assign ge    = trial >= {1'b0, d_cur};

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k+1] <= ge ? DW'(trial - {1'b0, d_cur}) : trial[DW-1:0];
            nq_ff[k+1]  <= {nq_cur[NW-2:0], ge};
            den_ff[k+1] <= d_cur;
            tag_ff[k+1] <= t_cur;
         end
      end
   end

   assign quo     = nq_ff[NW];
   assign tag_out = tag_ff[NW];

endmodule

/* hw/rtl/scl_budget.sv */
module scl_budget (
   input  logic                        clock,
   input  logic                        adv,
   input  scl_pkg::cfg_type            cfg,
   input  logic [7:0]                  power_limit,
   input  logic [7:0]                  power_buffer,
   input  logic [11:0]                 cap_voltage,
   output logic [scl_pkg::BUD_W-1:0]   budget
);
   import scl_pkg::*;

   logic signed [9:0]  l_w;
   logic [6:0]         t_w;
   logic [11:0]        span_w;
   logic [11:0]        vd_w;
   logic signed [10:0] pd_w;
   logic [1:0]         mode_in;
   logic [BDEN_W-1:0]  den_in;

   logic [1:0]         mode_ff;
   logic signed [9:0]  l_ff;
   logic               e_ff;
   logic signed [16:0] lt_ff;
   logic signed [23:0] p1_ff;
   logic [19:0]        p2_ff;
   logic [8:0]         maxp_ff;
   logic [BDEN_W-1:0]  den_ff;

   logic signed [31:0] nb_w;
   logic [30:0]        mag_w;
   logic [BNUM_W-1:0]  num_ff;
   logic [BDEN_W-1:0]  dv_ff;
   logic               neg_ff;

   logic [BNUM_W-1:0]  quo_w;
   logic               neg_w;
   logic signed [35:0] qs_w;
   logic signed [35:0] a_in;
   logic signed [35:0] a_ff;
   logic [44:0]        prod_in;
   logic [44:0]        prod_ff;
   logic [BUD_W-1:0]   budget_in;
   logic [BUD_W-1:0]   budget_ff;

   assign l_w    = $signed({2'b00, power_limit}) + 10'(cfg.power_offset);
   assign t_w    = (cfg.peak_time_tenths == 7'd0) ? 7'd1 : cfg.peak_time_tenths;
   assign span_w = cfg.slowdown_voltage - cfg.dead_voltage;
   assign vd_w   = cap_voltage - cfg.dead_voltage;
   assign pd_w   = $signed({2'b00, cfg.max_output_power}) - $signed({3'b000, power_limit});

   always_comb begin
      if (cap_voltage == 12'd0) begin
         mode_in = MODE_NOCAP;
         den_in  = 24'(t_w) * 24'd24;
      end else if (cap_voltage <= cfg.dead_voltage) begin
         mode_in = MODE_DEAD;
         den_in  = 24'(cap_voltage);
      end else if (cap_voltage < cfg.slowdown_voltage) begin
         mode_in = MODE_RAMP;
         den_in  = 24'(span_w) * 24'(cap_voltage);
      end else begin
         mode_in = MODE_FULL;
         den_in  = 24'(cap_voltage);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mode_ff <= mode_in;
         l_ff    <= l_w;
         e_ff    <= power_buffer > cfg.safe_buffer;
         lt_ff   <= 17'(l_w) * $signed({10'd0, t_w});
         p1_ff   <= 24'(pd_w) * $signed({11'd0, vd_w});
         p2_ff   <= 20'(power_limit) * 20'(span_w);
         maxp_ff <= cfg.max_output_power;
         den_ff  <= den_in;
      end
   end

   always_comb begin
      case (mode_ff)
         MODE_NOCAP: nb_w = 32'(lt_ff) + (e_ff ? 32'sd600 : 32'sd0);
         MODE_DEAD:  nb_w = 32'(l_ff) * 32'sd100;
         MODE_RAMP:  nb_w = (32'(p1_ff) + $signed({12'd0, p2_ff})) * 32'sd100;
         default:    nb_w = $signed({23'd0, maxp_ff}) * 32'sd100;
      endcase
   end

   assign mag_w = nb_w[31] ? 31'(-nb_w) : nb_w[30:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff <= {mag_w, 16'd0};
         dv_ff  <= den_ff;
         neg_ff <= nb_w[31];
      end
   end

   scl_div #(
      .NW(BNUM_W),
      .DW(BDEN_W),
      .TW(1)
   ) u_div (
      .clock   (clock),
      .adv     (adv),
      .num     (num_ff),
      .den     (dv_ff),
      .tag     (neg_ff),
      .quo     (quo_w),
      .tag_out (neg_w)
   );

   assign qs_w = $signed({2'b00, quo_w[33:0]});
   assign a_in = (neg_w ? -qs_w : qs_w) + (36'(cfg.current_offset) <<< 8);

   assign prod_in = (!a_ff[35] && (a_ff != 36'sd0)) ?
                    45'(a_ff[32:0]) * 45'(cfg.current_scale) : 45'd0;

   assign budget_in = (prod_ff[44:32] != 13'd0) ? {BUD_W{1'b1}} : prod_ff[31:16];

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff      <= a_in;
         prod_ff   <= prod_in;
         budget_ff <= budget_in;
      end
   end

   assign budget = budget_ff;

endmodule

/* hw/rtl/scl_lane.sv */
module scl_lane (
   input  logic                              clock,
   input  logic                              adv,
   input  logic signed [scl_pkg::CMD_W-1:0]  cmd,
   input  logic [scl_pkg::BUD_W-1:0]         budget,
   input  logic [scl_pkg::SUM_W-1:0]         sum,
   input  logic                              limited,
   output logic signed [scl_pkg::CMD_W-1:0]  wheel_out
);
   import scl_pkg::*;

   localparam int TAG_W = CMD_W + 2;

   logic signed [MAG_W-1:0] cx_w;
   logic [MAG_W-1:0]        mag_w;
   logic [LNUM_W-1:0]       prod_ff;
   logic [SUM_W-1:0]        den_ff;
   logic [TAG_W-1:0]        tag_ff;
   logic [LNUM_W-1:0]       quo_w;
   logic [TAG_W-1:0]        tag_w;
   logic signed [MAG_W:0]   q_w;
   logic [CMD_W-1:0]        res_in;
   logic [CMD_W-1:0]        wheel_out_ff;

   assign cx_w  = MAG_W'(cmd);
   assign mag_w = cx_w[MAG_W-1] ? MAG_W'(-cx_w) : cx_w;

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= LNUM_W'(mag_w) * LNUM_W'(budget);
         den_ff  <= sum;
         tag_ff  <= {limited, cmd[CMD_W-1], cmd};
      end
   end

   scl_div #(
      .NW(LNUM_W),
      .DW(SUM_W),
      .TW(TAG_W)
   ) u_div (
      .clock   (clock),
      .adv     (adv),
      .num     (prod_ff),
      .den     (den_ff),
      .tag     (tag_ff),
      .quo     (quo_w),
      .tag_out (tag_w)
   );

   assign q_w    = $signed({1'b0, quo_w[MAG_W-1:0]});
   assign res_in = tag_w[TAG_W-1] ? CMD_W'(tag_w[CMD_W] ? -q_w : q_w) : tag_w[CMD_W-1:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         wheel_out_ff <= res_in;
      end
   end

   assign wheel_out = wheel_out_ff;

endmodule

/* hw/rtl/supercap_wheel_current_limiter.sv */
// Each accepted item passes through the 47-step budget divider and then the 33-step
// per-wheel scaling divider, one step per stage.
// Throughput: one item per cycle; the whole pipeline holds only while a result waits
// at the output and the output side stalls.
// Reset clears all valid flags and loads the configuration registers with their defaults.
module supercap_wheel_current_limiter #(
   parameter int WHEELS = 4
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [7:0]                             req_power_limit,
   input  logic [7:0]                             req_power_buffer,
   input  logic [11:0]                            req_cap_voltage,
   input  logic signed [15:0]                     req_wheel_cmd_0,
   input  logic signed [15:0]                     req_wheel_cmd_1,
   input  logic signed [15:0]                     req_wheel_cmd_2,
   input  logic signed [15:0]                     req_wheel_cmd_3,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [15:0]                     rsp_wheel_out_0,
   output logic signed [15:0]                     rsp_wheel_out_1,
   output logic signed [15:0]                     rsp_wheel_out_2,
   output logic signed [15:0]                     rsp_wheel_out_3,
   output logic                                   rsp_was_limited,
   output logic [15:0]                            rsp_current_budget,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [scl_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [scl_pkg::CSR_DAT_W-1:0]          csr_wdata
);
   import scl_pkg::*;

   localparam int TOT_LAT = BUD_LAT + LANE_LAT;

   typedef struct packed {
      logic [MAX_WHEELS-1:0][CMD_W-1:0] cmds;
      logic [SUM_W-1:0]                 sum;
   } side_type;

   typedef struct packed {
      logic             limited;
      logic [BUD_W-1:0] budget;
   } merge_type;

   cfg_type     cfg_ff;
   logic        adv;
   logic        acc;
   logic [1:TOT_LAT] vld_ff;
   side_type    side_in;
   side_type    side_ff [1:BUD_LAT];
   merge_type   merge_in;
   merge_type   merge_ff [1:LANE_LAT];
   logic [BUD_W-1:0] budget_w;
   logic [MAX_WHEELS-1:0][CMD_W-1:0] out_w;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_POWER_OFFSET:     cfg_ff.power_offset     <= $signed(csr_wdata[6:0]);
            CSR_SAFE_BUFFER:      cfg_ff.safe_buffer      <= csr_wdata[7:0];
            CSR_PEAK_TIME_TENTHS: cfg_ff.peak_time_tenths <= csr_wdata[6:0];
            CSR_CURRENT_OFFSET:   cfg_ff.current_offset   <= $signed(csr_wdata[12:0]);
            CSR_DEAD_VOLTAGE:     cfg_ff.dead_voltage     <= csr_wdata[11:0];
            CSR_SLOWDOWN_VOLTAGE: cfg_ff.slowdown_voltage <= csr_wdata[11:0];
            CSR_MAX_OUTPUT_POWER: cfg_ff.max_output_power <= csr_wdata[8:0];
            CSR_CURRENT_SCALE:    cfg_ff.current_scale    <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   assign adv       = !vld_ff[TOT_LAT] || !rsp_stall;
   assign req_stall = !adv;
   assign acc       = req_valid && adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {acc, vld_ff[1:TOT_LAT-1]};
      end
   end

   always_comb begin
      logic [MAG_W-1:0] mag;
      side_in.cmds[0] = req_wheel_cmd_0;
      side_in.cmds[1] = req_wheel_cmd_1;
      side_in.cmds[2] = req_wheel_cmd_2;
      side_in.cmds[3] = req_wheel_cmd_3;
      side_in.sum = '0;
      for (int i = 0; i < WHEELS; i++) begin
         mag = side_in.cmds[i][CMD_W-1] ? MAG_W'(-$signed({1'b1, side_in.cmds[i]}))
                                        : MAG_W'(side_in.cmds[i]);
         side_in.sum = side_in.sum + SUM_W'(mag);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[1] <= side_in;
         for (int k = 2; k <= BUD_LAT; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   scl_budget u_budget (
      .clock        (clock),
      .adv          (adv),
      .cfg          (cfg_ff),
      .power_limit  (req_power_limit),
      .power_buffer (req_power_buffer),
      .cap_voltage  (req_cap_voltage),
      .budget       (budget_w)
   );

   assign merge_in.limited = side_ff[BUD_LAT].sum > SUM_W'(budget_w);
   assign merge_in.budget  = budget_w;

   always_ff @(posedge clock) begin
      if (adv) begin
         merge_ff[1] <= merge_in;
         for (int k = 2; k <= LANE_LAT; k++) begin
            merge_ff[k] <= merge_ff[k-1];
         end
      end
   end

   for (genvar i = 0; i < MAX_WHEELS; i++) begin : g_lane
      if (i < WHEELS) begin : g_used
         scl_lane u_lane (
            .clock     (clock),
            .adv       (adv),
            .cmd       ($signed(side_ff[BUD_LAT].cmds[i])),
            .budget    (budget_w),
            .sum       (side_ff[BUD_LAT].sum),
            .limited   (merge_in.limited),
            .wheel_out (out_w[i])
         );
      end else begin : g_unused
         assign out_w[i] = '0;
      end
   end

   assign rsp_valid          = vld_ff[TOT_LAT];
   assign rsp_wheel_out_0    = $signed(out_w[0]);
   assign rsp_wheel_out_1    = $signed(out_w[1]);
   assign rsp_wheel_out_2    = $signed(out_w[2]);
   assign rsp_wheel_out_3    = $signed(out_w[3]);
   assign rsp_was_limited    = merge_ff[LANE_LAT].limited;
   assign rsp_current_budget = merge_ff[LANE_LAT].budget;

   a_zero_budget: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_current_budget == 16'd0) |->
         (rsp_wheel_out_0 == 16'sd0) && (rsp_wheel_out_1 == 16'sd0) &&
         (rsp_wheel_out_2 == 16'sd0) && (rsp_wheel_out_3 == 16'sd0))
      else $error("nonzero wheel output with zero budget");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while the result is held");

   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

/* tb/sv/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import scl_pkg::*;

   localparam int LATENCY = 87;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic signed [15:0] wheel[4];
      logic               limited;
      logic [15:0]        budget;
   } limit_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_power_limit = '0;
   logic [7:0] req_power_buffer = '0;
   logic [11:0] req_cap_voltage = '0;
   logic signed [15:0] req_wheel_cmd_0 = '0;
   logic signed [15:0] req_wheel_cmd_1 = '0;
   logic signed [15:0] req_wheel_cmd_2 = '0;
   logic signed [15:0] req_wheel_cmd_3 = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_wheel_out_0, rsp_wheel_out_1, rsp_wheel_out_2, rsp_wheel_out_3;
   logic rsp_was_limited;
   logic [15:0] rsp_current_budget;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   cfg_type limiter_cfg = CFG_RESET;
   limit_result_t expected_results[$];
   int error_count = 0;
   longint cycle_count = 0;
   int hold_cycles = 0;
   bit rsp_random_stall = 1'b1;

   supercap_wheel_current_limiter dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch in %s: got %0d, expected %0d", what, got, want);
      error_count++;
   endtask

   function automatic longint trunc_div(input longint n, input longint d);
      longint q;
      q = (n < 0 ? -n : n) / (d < 0 ? -d : d);
      return ((n < 0) != (d < 0)) ? -q : q;
   endfunction

   function automatic limit_result_t predict_limit(input logic [7:0] limit,
         input logic [7:0] buffer, input logic [11:0] volts, input logic signed [15:0] cmd[4]);
      limit_result_t r;
      longint lim, l, v, dead, slow, maxp, t, e, amps, budget, sum, span, p;
      lim = limit;
      l = lim + longint'(limiter_cfg.power_offset);
      v = volts;
      dead = limiter_cfg.dead_voltage;
      slow = limiter_cfg.slowdown_voltage;
      maxp = limiter_cfg.max_output_power;
      if (v == 0) begin
         t = limiter_cfg.peak_time_tenths;
         if (t == 0) t = 1;
         e = (buffer > limiter_cfg.safe_buffer) ? 1 : 0;
         amps = trunc_div((l * t + e * 600) * 65536, 24 * t);
      end else if (v <= dead) begin
         amps = trunc_div(l * 100 * 65536, v);
      end else if (v < slow) begin
         span = slow - dead;
         p = (maxp - lim) * (v - dead) + lim * span;
         amps = trunc_div(p * 100 * 65536, span * v);
      end else begin
         amps = trunc_div(maxp * 100 * 65536, v);
      end
      amps += longint'(limiter_cfg.current_offset) * 256;
      if (amps <= 0) budget = 0;
      else begin
         budget = trunc_div(amps * longint'(limiter_cfg.current_scale), 65536);
         if (budget > 65535) budget = 65535;
      end
      sum = 0;
      for (int i = 0; i < 4; i++) begin
         r.wheel[i] = '0;
         if (i < 4) sum += (cmd[i] < 0) ? -longint'(cmd[i]) : longint'(cmd[i]);
      end
      r.limited = sum > budget;
      for (int i = 0; i < 4; i++)
         r.wheel[i] = r.limited ? 16'(trunc_div(longint'(cmd[i]) * budget, sum)) : cmd[i];
      r.budget = 16'(budget);
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result count", 1, 0);
         end else begin
            limit_result_t w;
            w = expected_results.pop_front();
            if (rsp_wheel_out_0 !== w.wheel[0]) report_mismatch("wheel 0", rsp_wheel_out_0, w.wheel[0]);
            if (rsp_wheel_out_1 !== w.wheel[1]) report_mismatch("wheel 1", rsp_wheel_out_1, w.wheel[1]);
            if (rsp_wheel_out_2 !== w.wheel[2]) report_mismatch("wheel 2", rsp_wheel_out_2, w.wheel[2]);
            if (rsp_wheel_out_3 !== w.wheel[3]) report_mismatch("wheel 3", rsp_wheel_out_3, w.wheel[3]);
            if (rsp_was_limited !== w.limited) report_mismatch("was_limited", rsp_was_limited, w.limited);
            if (rsp_current_budget !== w.budget) report_mismatch("budget", rsp_current_budget, w.budget);
         end
      end
   end

   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else if (rsp_random_stall) begin
         rsp_stall <= ($urandom_range(0, 4) == 0) ? 1'b0 : ($urandom_range(0, 1) == 1);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_item(input logic [7:0] limit, input logic [7:0] buffer,
         input logic [11:0] volts, input logic signed [15:0] c0, input logic signed [15:0] c1,
         input logic signed [15:0] c2, input logic signed [15:0] c3, input bit no_gap = 0);
      logic signed [15:0] cmd[4];
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 4);
      cmd[0] = c0; cmd[1] = c1; cmd[2] = c2; cmd[3] = c3;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_power_limit <= limit;
      req_power_buffer <= buffer;
      req_cap_voltage <= volts;
      req_wheel_cmd_0 <= c0;
      req_wheel_cmd_1 <= c1;
      req_wheel_cmd_2 <= c2;
      req_wheel_cmd_3 <= c3;
      do @(posedge clock); while (req_stall);
      expected_results.push_back(predict_limit(limit, buffer, volts, cmd));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      wait (expected_results.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input int value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DAT_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_POWER_OFFSET:     limiter_cfg.power_offset = 7'(value);
         CSR_SAFE_BUFFER:      limiter_cfg.safe_buffer = 8'(value);
         CSR_PEAK_TIME_TENTHS: limiter_cfg.peak_time_tenths = 7'(value);
         CSR_CURRENT_OFFSET:   limiter_cfg.current_offset = 13'(value);
         CSR_DEAD_VOLTAGE:     limiter_cfg.dead_voltage = 12'(value);
         CSR_SLOWDOWN_VOLTAGE: limiter_cfg.slowdown_voltage = 12'(value);
         CSR_MAX_OUTPUT_POWER: limiter_cfg.max_output_power = 9'(value);
         CSR_CURRENT_SCALE:    limiter_cfg.current_scale = 12'(value);
         default: ;
      endcase
   endtask

   function automatic logic signed [15:0] random_cmd();
      case ($urandom_range(0, 5))
         0: return -16'sd32768;
         1: return 16'sd32767;
         2: return 16'($urandom_range(0, 2000)) - 16'sd1000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_random_item();
      logic [11:0] volts;
      case ($urandom_range(0, 4))
         0: volts = 12'd0;
         1: volts = 12'($urandom_range(1, limiter_cfg.dead_voltage + 1));
         2: volts = 12'($urandom_range(limiter_cfg.dead_voltage, limiter_cfg.slowdown_voltage));
         3: volts = 12'($urandom_range(0, 3000));
         default: volts = 12'($urandom);
      endcase
      send_item(8'($urandom), 8'($urandom), volts,
                random_cmd(), random_cmd(), random_cmd(), random_cmd());
   endtask

   task automatic test_directed();
      send_item(0, 0, 0, 0, 0, 0, 0);
      send_item(255, 255, 0, 100, -100, 50, -50);
      send_item(255, 0, 0, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
      send_item(80, 20, 1, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
      send_item(80, 20, 1200, 500, -500, 500, -500);
      send_item(80, 20, 1500, 1000, 2000, -3000, 4000);
      send_item(80, 20, 1800, 1000, 2000, -3000, 4000);
      send_item(0, 20, 4095, -1, 1, -1, 1);
      send_item(255, 255, 3000, 0, 0, 0, 0);
      send_item(60, 10, 0, 5, 5, 5, 5);
      send_item(60, 11, 0, -16'sd32768, 0, 0, 0);
      drain_results();
   endtask

   task automatic test_register_extremes();
      write_register(CSR_POWER_OFFSET, -50);
      write_register(CSR_CURRENT_OFFSET, -2560);
      write_register(CSR_PEAK_TIME_TENTHS, 0);
      write_register(CSR_SAFE_BUFFER, 0);
      write_register(CSR_CURRENT_SCALE, 4095);
      send_item(0, 1, 0, 100, 0, 0, 0);
      send_item(40, 1, 100, 100, 0, 0, 0);
      send_item(255, 0, 0, 100, 0, 0, 0);
      drain_results();
      write_register(CSR_POWER_OFFSET, 50);
      write_register(CSR_CURRENT_OFFSET, 2560);
      write_register(CSR_SAFE_BUFFER, 250);
      write_register(CSR_PEAK_TIME_TENTHS, 100);
      write_register(CSR_DEAD_VOLTAGE, 0);
      write_register(CSR_SLOWDOWN_VOLTAGE, 3000);
      write_register(CSR_MAX_OUTPUT_POWER, 500);
      send_item(255, 251, 0, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
      send_item(255, 0, 1, 16'sd32767, -16'sd32768, 0, 0);
      send_item(10, 0, 1500, 1000, 2000, 3000, 4000);
      send_item(10, 0, 3000, 1000, 2000, 3000, 4000);
      drain_results();
      write_register(CSR_CURRENT_SCALE, 0);
      write_register(CSR_DEAD_VOLTAGE, 3000);
      write_register(CSR_SLOWDOWN_VOLTAGE, 0);
      write_register(CSR_MAX_OUTPUT_POWER, 0);
      send_item(100, 0, 2000, 1, 0, 0, 0);
      send_item(100, 0, 0, 0, 0, 0, 0);
      drain_results();
      write_register(4'd9, 123);
      write_register(4'd15, 0);
   endtask

   task automatic test_random_settings();
      for (int phase = 0; phase < 7; phase++) begin
         write_register(CSR_POWER_OFFSET, $urandom_range(0, 100) - 50);
         write_register(CSR_SAFE_BUFFER, $urandom_range(0, 250));
         write_register(CSR_PEAK_TIME_TENTHS, $urandom_range(0, 100));
         write_register(CSR_CURRENT_OFFSET, $urandom_range(0, 5120) - 2560);
         write_register(CSR_DEAD_VOLTAGE, $urandom_range(0, 2000));
         write_register(CSR_SLOWDOWN_VOLTAGE, $urandom_range(limiter_cfg.dead_voltage, 3000));
         write_register(CSR_MAX_OUTPUT_POWER, $urandom_range(0, 500));
         write_register(CSR_CURRENT_SCALE, (phase == 0) ? 819 : $urandom_range(0, 4095));
         rsp_random_stall = (phase != 3);
         repeat (180) send_random_item();
         drain_results();
      end
      rsp_random_stall = 1'b1;
   endtask

   task automatic test_backpressure();
      hold_cycles <= 300;
      repeat (150) send_random_item();
      drain_results();
      repeat (20) send_item(8'($urandom), 8'($urandom), 12'($urandom_range(0, 3000)),
                            random_cmd(), random_cmd(), random_cmd(), random_cmd(), 1);
      drain_results();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_register_extremes();
      test_random_settings();
      test_backpressure();
      if (error_count == 0) $display("testbench OK");
      else $display("testbench NOT OK");
      $finish;
   end
endmodule

/* sim.f */
hw/rtl/scl_pkg.sv
hw/rtl/scl_div.sv
hw/rtl/scl_budget.sv
hw/rtl/scl_lane.sv
hw/rtl/supercap_wheel_current_limiter.sv
tb/sv/testbench.sv
